/* design/mie_pkg.sv */
// ----------------------------------------------------------------------------
// mie_pkg
// Shared types, opcodes and load formats for the immediate execute block.
// ----------------------------------------------------------------------------
package mie_pkg;

	localparam int RegCount = 32;
	localparam int RegIdxW  = 5;

	localparam logic [5:0] OP_J      = 6'h02;
	localparam logic [5:0] OP_JAL    = 6'h03;
	localparam logic [5:0] OP_BEQ    = 6'h04;
	localparam logic [5:0] OP_BNE    = 6'h05;
	localparam logic [5:0] OP_BLEZ   = 6'h06;
	localparam logic [5:0] OP_BGTZ   = 6'h07;
	localparam logic [5:0] OP_ADDI   = 6'h08;
	localparam logic [5:0] OP_ADDIU  = 6'h09;
	localparam logic [5:0] OP_SLTI   = 6'h0A;
	localparam logic [5:0] OP_SLTIU  = 6'h0B;
	localparam logic [5:0] OP_ANDI   = 6'h0C;
	localparam logic [5:0] OP_ORI    = 6'h0D;
	localparam logic [5:0] OP_XORI   = 6'h0E;
	localparam logic [5:0] OP_LUI    = 6'h0F;
	localparam logic [5:0] OP_BEQL   = 6'h14;
	localparam logic [5:0] OP_BNEL   = 6'h15;
	localparam logic [5:0] OP_BLEZL  = 6'h16;
	localparam logic [5:0] OP_DADDI  = 6'h18;
	localparam logic [5:0] OP_DADDIU = 6'h19;
	localparam logic [5:0] OP_LB     = 6'h20;
	localparam logic [5:0] OP_LW     = 6'h23;
	localparam logic [5:0] OP_LBU    = 6'h24;
	localparam logic [5:0] OP_LHU    = 6'h25;
	localparam logic [5:0] OP_LWU    = 6'h27;
	localparam logic [5:0] OP_SB     = 6'h28;
	localparam logic [5:0] OP_SH     = 6'h29;
	localparam logic [5:0] OP_SW     = 6'h2B;
	localparam logic [5:0] OP_CACHE  = 6'h2F;
	localparam logic [5:0] OP_LD     = 6'h37;
	localparam logic [5:0] OP_SD     = 6'h3F;

	localparam logic [2:0] LF_NONE = 3'd0;
	localparam logic [2:0] LF_LB   = 3'd1;
	localparam logic [2:0] LF_LBU  = 3'd2;
	localparam logic [2:0] LF_LHU  = 3'd3;
	localparam logic [2:0] LF_LW   = 3'd4;
	localparam logic [2:0] LF_LWU  = 3'd5;
	localparam logic [2:0] LF_LD   = 3'd6;

	localparam logic [1:0] MK_NONE  = 2'd0;
	localparam logic [1:0] MK_READ  = 2'd1;
	localparam logic [1:0] MK_WRITE = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_UNDEF = 2'd1;
	localparam logic [1:0] ST_OVF   = 2'd2;

	localparam logic [1:0] SZ_BYTE = 2'd0;
	localparam logic [1:0] SZ_HALF = 2'd1;
	localparam logic [1:0] SZ_WORD = 2'd2;
	localparam logic [1:0] SZ_DWORD = 2'd3;

	localparam int LuiShift = 16;

	typedef struct packed {
		logic        command;
		logic [31:0] instruction;
		logic [63:0] load_data;
	} in_beat_t;

	typedef struct packed {
		logic [63:0] next_fetch_pc;
		logic [1:0]  mem_kind;
		logic [63:0] mem_address;
		logic [1:0]  mem_size;
		logic [63:0] mem_write_data;
		logic        reg_write_enable;
		logic [4:0]  reg_index;
		logic [63:0] reg_value;
		logic [1:0]  status;
	} out_beat_t;

	// register file write request
	typedef struct packed {
		logic        en;
		logic [4:0]  idx;
		logic [63:0] data;
	} rf_wr_t;

endpackage

/* design/mie_regfile.sv */
// ----------------------------------------------------------------------------
// mie_regfile
// 64-bit general register file, two synchronous read ports, one write port,
// per-entry valid bits so reset reads as zero and r0 always reads zero.
// ----------------------------------------------------------------------------
module mie_regfile import mie_pkg::*; #(
	parameter int REGISTER_COUNT = RegCount
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [$clog2(REGISTER_COUNT)-1:0] ra_idx,
	input  logic [$clog2(REGISTER_COUNT)-1:0] rb_idx,
	output logic [63:0]                       ra_data,
	output logic [63:0]                       rb_data,
	input  rf_wr_t                            wr
);
	localparam int IW = $clog2(REGISTER_COUNT);

	logic [63:0] mem [REGISTER_COUNT];
	logic [REGISTER_COUNT-1:0] vld_q;
	logic [63:0] ra_raw_q, rb_raw_q;
	logic ra_ok_q, rb_ok_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.idx[IW-1:0]] <= wr.data;
		end
		ra_raw_q <= mem[ra_idx];
		rb_raw_q <= mem[rb_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			ra_ok_q <= 1'b0;
			rb_ok_q <= 1'b0;
		end else begin
			if (wr.en && wr.idx[IW-1:0] != '0) begin
				vld_q[wr.idx[IW-1:0]] <= 1'b1;
			end
			ra_ok_q <= vld_q[ra_idx] && ra_idx != '0;
			rb_ok_q <= vld_q[rb_idx] && rb_idx != '0;
		end
	end

	assign ra_data = ra_ok_q ? ra_raw_q : 64'd0;
	assign rb_data = rb_ok_q ? rb_raw_q : 64'd0;

endmodule

/* design/mips64_immediate_execute.sv */
// ----------------------------------------------------------------------------
// mips64_immediate_execute
// Executes MIPS64 I-type/J-type instructions against a 32x64 register file.
// ----------------------------------------------------------------------------
//  channel | dir | handshake       | payload
//  in      | in  | in_valid/ready  | in_beat_t (command, instruction, load_data)
//  out     | out | out_valid/ready | out_beat_t
//  cfg     | in  | APB             | start_address at 0x0
//
// One beat per cycle sustained unless the output stalls. Stage 1 reads the
// register file memory; stage 2 executes, writes back and forwards the write
// to the operands of the next beat. Results land in a two-entry output
// buffer. Reset sets the PCs to 4 and 8 and clears the pending load and
// register valid bits at once. A full output buffer holds the pipeline.
module mips64_immediate_execute import mie_pkg::*; #(
	parameter int REGISTER_COUNT = RegCount
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_beat_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_beat_t   out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);
	localparam int IW = $clog2(REGISTER_COUNT);

	logic [63:0] start_q, dspc_q, fpc_q;
	logic [4:0]  plr_q;
	logic [2:0]  plf_q;

	logic        v_s1;
	in_beat_t    b_s1;
	rf_wr_t      wr_s2;   // this cycle's writeback, for forwarding
	logic [63:0] ra_mem, rb_mem, a, b;

	// output buffer
	out_beat_t   ob_q [2];
	logic [1:0]  ob_cnt_q;
	logic        ob_rd_q, ob_wr_q;

	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite && paddr == 3'd0;
	assign pready = 1'b1;
	assign prdata = start_q;

	// stage 1 advances when stage 2 can execute: buffer space counting in-flight
	logic exec;
	assign exec = v_s1 && (ob_cnt_q != 2'd2);
	assign in_ready = !v_s1 || exec;

	logic [4:0] rs_in, rt_in;
	assign rs_in = in_data.instruction[25:21];
	assign rt_in = in_data.instruction[20:16];

	mie_regfile #(.REGISTER_COUNT(REGISTER_COUNT)) u_rf (
		.clk, .arst_n,
		.ra_idx (rs_in[IW-1:0]),
		.rb_idx (rt_in[IW-1:0]),
		.ra_data(ra_mem),
		.rb_data(rb_mem),
		.wr     (wr_s2)
	);

	// forward the write performed in the same edge as the read
	rf_wr_t fw_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fw_q <= '0;
		else if (in_valid && in_ready) fw_q <= wr_s2;
		else if (wr_s2.en) fw_q <= '0;
	end
	// held beat: regfile outputs stale if stage stalled, so re-read via buffers
	logic [63:0] ra_h_q, rb_h_q;
	logic        hold_q;
	logic [63:0] ra_n, rb_n;
	always_comb begin
		ra_n = hold_q ? ra_h_q : ra_mem;
		rb_n = hold_q ? rb_h_q : rb_mem;
		if (!hold_q && fw_q.en && fw_q.idx == b_s1.instruction[25:21]) ra_n = fw_q.data;
		if (!hold_q && fw_q.en && fw_q.idx == b_s1.instruction[20:16]) rb_n = fw_q.data;
		a = ra_n;
		b = rb_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			hold_q <= 1'b0;
		end else begin
			if (in_ready) v_s1 <= in_valid;
			hold_q <= v_s1 && !exec;
		end
	end
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) b_s1 <= in_data;
		if (v_s1 && !exec) begin
			ra_h_q <= a;
			rb_h_q <= b;
		end
	end

	// ---------------- execute ----------------
	logic [5:0]  op;
	logic [4:0]  rt;
	logic [15:0] imm;
	logic [63:0] simm, btgt, jtgt, addr, npc, fetch, sum64, v;
	logic [31:0] sum32;
	logic        skip, take;
	out_beat_t   r;
	rf_wr_t      w;
	logic [2:0]  nplf;
	logic [4:0]  nplr;

	always_comb begin
		op    = b_s1.instruction[31:26];
		rt    = b_s1.instruction[20:16];
		imm   = b_s1.instruction[15:0];
		simm  = {{48{imm[15]}}, imm};
		btgt  = dspc_q + {simm[61:0], 2'b00};
		jtgt  = {dspc_q[63:28], b_s1.instruction[25:0], 2'b00};
		addr  = a + simm;
		sum64 = a + simm;
		sum32 = a[31:0] + simm[31:0];
		npc   = fpc_q;
		skip  = 1'b0;
		take  = 1'b0;
		r     = '0;
		w     = '0;
		nplf  = plf_q;
		nplr  = plr_q;
		v     = '0;
		if (b_s1.command) begin
			unique case (plf_q)
				LF_LB:   v = {{56{b_s1.load_data[7]}}, b_s1.load_data[7:0]};
				LF_LBU:  v = {56'd0, b_s1.load_data[7:0]};
				LF_LHU:  v = {48'd0, b_s1.load_data[15:0]};
				LF_LW:   v = {{32{b_s1.load_data[31]}}, b_s1.load_data[31:0]};
				LF_LWU:  v = {32'd0, b_s1.load_data[31:0]};
				LF_LD:   v = b_s1.load_data;
				default: v = '0;
			endcase
			w.en   = plf_q != LF_NONE;
			w.idx  = plr_q;
			w.data = v;
			nplf   = LF_NONE;
			nplr   = '0;
			fetch  = dspc_q;
		end else begin
			w.idx = rt;
			unique case (op)
				OP_J:   npc = jtgt;
				OP_JAL: begin npc = jtgt; w = '{1'b1, 5'd31, fpc_q}; end
				OP_BEQ:  take = a == b;
				OP_BNE:  take = a != b;
				OP_BLEZ: take = a[63] || a == '0;
				OP_BGTZ: take = !a[63] && a != '0;
				OP_BEQL: begin take = a == b; skip = !take; end
				OP_BNEL: begin take = a != b; skip = !take; end
				OP_BLEZL: begin take = a[63] || a == '0; skip = !take; end
				OP_ADDI: begin
					if ((a[31] ^ sum32[31]) & (simm[31] ^ sum32[31])) r.status = ST_OVF;
					else begin w.en = 1'b1; w.data = {{32{sum32[31]}}, sum32}; end
				end
				OP_ADDIU: begin w.en = 1'b1; w.data = {{32{sum32[31]}}, sum32}; end
				OP_SLTI:  begin w.en = 1'b1; w.data = {63'd0, $signed(a) < $signed(simm)}; end
				OP_SLTIU: begin w.en = 1'b1; w.data = {63'd0, a < simm}; end
				OP_ANDI:  begin w.en = 1'b1; w.data = a & {48'd0, imm}; end
				OP_ORI:   begin w.en = 1'b1; w.data = a | {48'd0, imm}; end
				OP_XORI:  begin w.en = 1'b1; w.data = a ^ {48'd0, imm}; end
				OP_LUI: begin
					w.en = 1'b1;
					w.data = {{32{imm[15]}}, imm, {LuiShift{1'b0}}};
				end
				OP_DADDI: begin
					if ((a[63] ^ sum64[63]) & (simm[63] ^ sum64[63])) r.status = ST_OVF;
					else begin w.en = 1'b1; w.data = sum64; end
				end
				OP_DADDIU: begin w.en = 1'b1; w.data = sum64; end
				OP_LB:  begin r.mem_kind = MK_READ; r.mem_size = SZ_BYTE; nplf = LF_LB; end
				OP_LBU: begin r.mem_kind = MK_READ; r.mem_size = SZ_BYTE; nplf = LF_LBU; end
				OP_LHU: begin r.mem_kind = MK_READ; r.mem_size = SZ_HALF; nplf = LF_LHU; end
				OP_LW:  begin r.mem_kind = MK_READ; r.mem_size = SZ_WORD; nplf = LF_LW; end
				OP_LWU: begin r.mem_kind = MK_READ; r.mem_size = SZ_WORD; nplf = LF_LWU; end
				OP_LD:  begin r.mem_kind = MK_READ; r.mem_size = SZ_DWORD; nplf = LF_LD; end
				OP_SB: begin
					r.mem_kind = MK_WRITE; r.mem_size = SZ_BYTE;
					r.mem_write_data = {56'd0, b[7:0]};
				end
				OP_SH: begin
					r.mem_kind = MK_WRITE; r.mem_size = SZ_HALF;
					r.mem_write_data = {48'd0, b[15:0]};
				end
				OP_SW: begin
					r.mem_kind = MK_WRITE; r.mem_size = SZ_WORD;
					r.mem_write_data = {32'd0, b[31:0]};
				end
				OP_SD: begin r.mem_kind = MK_WRITE; r.mem_size = SZ_DWORD; r.mem_write_data = b; end
				OP_CACHE: ;
				default: r.status = ST_UNDEF;
			endcase
			if (take) npc = btgt;
			if (r.mem_kind != MK_NONE) r.mem_address = addr;
			if (r.mem_kind == MK_READ) nplr = rt;
			fetch = skip ? npc : dspc_q;
		end
		if (w.idx == '0) w.en = 1'b0;
		if (!w.en) w = '0;
		r.next_fetch_pc    = fetch;
		r.reg_write_enable = w.en;
		r.reg_index        = w.idx;
		r.reg_value        = w.data;
	end

	assign wr_s2 = exec ? w : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			dspc_q  <= 64'd4;
			fpc_q   <= 64'd8;
			plr_q   <= '0;
			plf_q   <= LF_NONE;
		end else if (cfg_wr) begin
			start_q <= pwdata;
			dspc_q  <= pwdata + 64'd4;
			fpc_q   <= pwdata + 64'd8;
		end else if (exec) begin
			plr_q <= nplr;
			plf_q <= nplf;
			if (!b_s1.command) begin
				dspc_q <= skip ? npc + 64'd4 : npc;
				fpc_q  <= skip ? npc + 64'd8 : npc + 64'd4;
			end
		end
	end

	// output FIFO, two entries
	logic pop;
	assign pop = out_valid && out_ready;
	always_ff @(posedge clk) begin
		if (exec) ob_q[ob_wr_q] <= r;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_cnt_q <= '0;
			ob_rd_q  <= 1'b0;
			ob_wr_q  <= 1'b0;
		end else begin
			if (exec) ob_wr_q <= !ob_wr_q;
			if (pop)  ob_rd_q <= !ob_rd_q;
			ob_cnt_q <= ob_cnt_q + {1'b0, exec} - {1'b0, pop};
		end
	end
	assign out_valid = ob_cnt_q != 2'd0;
	assign out_data  = ob_q[ob_rd_q];

	assert property (@(posedge clk) disable iff (!arst_n) ob_cnt_q != 2'd3)
		else $error("output buffer overflow");
	assert property (@(posedge clk) disable iff (!arst_n) exec |-> ob_cnt_q != 2'd2)
		else $error("execute into full buffer");
	assert property (@(posedge clk) disable iff (!arst_n) wr_s2.en |-> wr_s2.idx != 5'd0)
		else $error("write to r0");
	assert property (@(posedge clk) disable iff (!arst_n) (v_s1 && !exec) |=> v_s1)
		else $error("stalled beat lost");

endmodule
